FILE: rtl/obps_pkg.sv
// ---------------------------------------------------------------------------
// obps_pkg
// Shared types and constants of the odd-only bitmap prime sieve: field
// widths, fill pattern, status codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
package obps_pkg;

	// Field and internal widths
	localparam int LIM_W  = 21;          // configured limit
	localparam int IDX_W  = LIM_W;       // bit index into the odd map
	localparam int BYTE_W = IDX_W - 3;   // byte index into the odd map
	localparam int P_W    = 12;          // sieving prime, p*p stays within the limit
	localparam int SQ_W   = LIM_W + 1;   // p*p, one past the limit at loop exit
	localparam int CNT_W  = 17;          // prime count
	localparam int NUM_W  = 32;          // query number

	localparam logic [P_W-1:0]  INIT_P  = P_W'(5);
	localparam logic [SQ_W-1:0] INIT_SQ = SQ_W'(25);

	// Map fill: byte 0 is special, the rest repeats with period three
	localparam logic [7:0] FIRST_BYTE = 8'h6e;
	localparam logic [7:0] FILL_PAT [0:2] = '{8'd219, 8'd182, 8'd109};
	localparam logic [1:0] PHASE_NEXT [0:2] = '{2'd1, 2'd2, 2'd0};

	// Item kinds
	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_BUILT = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic build_start;
		logic q_accept;
		logic fill_wr;
		logic p_rd;
		logic p_adv;
		logic j_init;
		logic clr_rd;
		logic clr_wr;
		logic cnt_init;
		logic cnt_rd;
		logic cnt_commit;
		logic load_build;
		logic load_query;
	} obps_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_top_byte;
		logic sq_gt_lim;
		logic cand_set;
		logic j_gt_top;
		logic out_free;
	} obps_sts_t;

endpackage

FILE: rtl/obps_ram.sv
// ---------------------------------------------------------------------------
// obps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while read enable is low.
// ---------------------------------------------------------------------------
module obps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/obps_ctrl.sv
// ---------------------------------------------------------------------------
// obps_ctrl
// Sequencer of the sieve: accepts items, steps the build through fill,
// sieve and count, and hands results to the output register.
// ---------------------------------------------------------------------------
module obps_ctrl
	import obps_pkg::obps_cmd_t;
	import obps_pkg::obps_sts_t;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      kind,
	output logic      s_tready,
	input  obps_sts_t sts,
	output obps_cmd_t cmd
);
	import obps_pkg::*;

	typedef enum logic [9:0] {
		IDLE     = 10'b00_0000_0001,
		FILL     = 10'b00_0000_0010,
		P_RD     = 10'b00_0000_0100,
		P_CHK    = 10'b00_0000_1000,
		CLR_RD   = 10'b00_0001_0000,
		CLR_WR   = 10'b00_0010_0000,
		CNT      = 10'b00_0100_0000,
		CNT_LAST = 10'b00_1000_0000,
		B_DONE   = 10'b01_0000_0000,
		Q_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (kind == KIND_QUERY) begin
						cmd.q_accept = 1'b1;
						state_d      = Q_DONE;
					end else begin
						cmd.build_start = 1'b1;
						state_d         = FILL;
					end
				end
			end
			FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.at_top_byte) begin
					state_d = P_RD;
				end
			end
			P_RD: begin
				if (sts.sq_gt_lim) begin
					cmd.cnt_init = 1'b1;
					state_d      = CNT;
				end else begin
					cmd.p_rd = 1'b1;
					state_d  = P_CHK;
				end
			end
			P_CHK: begin
				if (sts.cand_set) begin
					cmd.j_init = 1'b1;
					state_d    = CLR_RD;
				end else begin
					cmd.p_adv = 1'b1;
					state_d   = P_RD;
				end
			end
			CLR_RD: begin
				if (sts.j_gt_top) begin
					cmd.p_adv = 1'b1;
					state_d   = P_RD;
				end else begin
					cmd.clr_rd = 1'b1;
					state_d    = CLR_WR;
				end
			end
			CLR_WR: begin
				cmd.clr_wr = 1'b1;
				state_d    = CLR_RD;
			end
			CNT: begin
				cmd.cnt_rd = 1'b1;
				if (sts.at_top_byte) begin
					state_d = CNT_LAST;
				end
			end
			CNT_LAST: begin
				cmd.cnt_commit = 1'b1;
				state_d        = B_DONE;
			end
			B_DONE: begin
				if (sts.out_free) begin
					cmd.load_build = 1'b1;
					state_d        = IDLE;
				end
			end
			Q_DONE: begin
				if (sts.out_free) begin
					cmd.load_query = 1'b1;
					state_d        = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/obps_dp.sv
// ---------------------------------------------------------------------------
// obps_dp
// Datapath of the sieve: limit register, map RAM, sieve counters, prime
// count accumulator, query evaluation and the output register.
// ---------------------------------------------------------------------------
module obps_dp
	import obps_pkg::obps_cmd_t;
	import obps_pkg::obps_sts_t;
	import obps_pkg::LIM_W;
	import obps_pkg::NUM_W;
	import obps_pkg::CNT_W;
#(
	parameter int MAX_LIMIT = 1048576
) (
	input  logic             clk,
	input  logic             arst_n,
	input  obps_cmd_t        cmd,
	output obps_sts_t        sts,
	input  logic             cfg_valid,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic [NUM_W-1:0] query_number,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic             is_prime,
	output logic [CNT_W-1:0] prime_count,
	output logic [1:0]       status
);
	import obps_pkg::*;

	localparam int MAP_BYTES = ((MAX_LIMIT - 1) >> 4) + 1;
	localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	function automatic logic [3:0] ones8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int b = 0; b < 8; b++) begin
			c = c + 4'(v[b]);
		end
		return c;
	endfunction

	// Control state
	logic [LIM_W-1:0] upper_limit_q;
	logic             map_valid_q;
	logic [CNT_W-1:0] stored_count_q;
	logic [LIM_W-1:0] built_limit_q;
	logic             acc_v_q;
	logic             m_tvalid_q;

	// Working registers
	logic [LIM_W-1:0]  lim_q;
	logic [IDX_W-1:0]  top_q;
	logic [BYTE_W-1:0] k_q;
	logic [1:0]        phase_q;
	logic [P_W-1:0]    p_q;
	logic [SQ_W-1:0]   sq_q;
	logic [IDX_W-1:0]  j_q;
	logic [CNT_W-1:0]  acc_q;
	logic [NUM_W-1:0]  num_q;
	logic              is_prime_q;
	logic [CNT_W-1:0]  prime_count_q;
	logic [1:0]        status_q;

	// Map RAM ports
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;

	// Effective limit and last odd index for a new build
	logic [LIM_W-1:0] lim_d;
	logic [IDX_W-1:0] top_d;
	logic [BYTE_W-1:0] top_byte;
	logic [7:0]        fill_byte, fill_mask;
	logic              q_bit;
	status_t           q_status;
	logic              q_prime;
	logic [CNT_W-1:0]  acc_sum;

	always_comb begin
		if (32'(upper_limit_q) > 32'(MAX_LIMIT)) begin
			lim_d = LIM_W'(MAX_LIMIT);
		end else begin
			lim_d = upper_limit_q;
		end
		if (lim_d == '0) begin
			top_d = '0;
		end else begin
			top_d = IDX_W'((lim_d - LIM_W'(1)) >> 1);
		end
	end

	assign top_byte = top_q[IDX_W-1:3];

	// Fill byte, with bits past the limit dropped
	assign fill_mask = sts.at_top_byte ? 8'((9'd2 << top_q[2:0]) - 9'd1) : 8'hff;
	assign fill_byte = ((k_q == '0) ? FIRST_BYTE : FILL_PAT[phase_q]) & fill_mask;

	// Status to controller
	assign sts.at_top_byte = (k_q == top_byte);
	assign sts.sq_gt_lim   = (sq_q > SQ_W'(lim_q));
	assign sts.cand_set    = rdata[p_q[3:1]];
	assign sts.j_gt_top    = (j_q > top_q);
	assign sts.out_free    = !m_tvalid_q || m_tready;

	// RAM write port
	assign we    = cmd.fill_wr || cmd.clr_wr;
	assign waddr = cmd.fill_wr ? ADDR_W'(k_q) : ADDR_W'(j_q >> 3);
	assign wdata = cmd.fill_wr ? fill_byte : (rdata & ~(8'd1 << j_q[2:0]));

	// RAM read port
	assign re = cmd.q_accept || cmd.p_rd || cmd.clr_rd || cmd.cnt_rd;
	always_comb begin
		priority if (cmd.q_accept) begin
			raddr = ADDR_W'(query_number >> 4);
		end else if (cmd.p_rd) begin
			raddr = ADDR_W'(p_q >> 4);
		end else if (cmd.clr_rd) begin
			raddr = ADDR_W'(j_q >> 3);
		end else begin
			raddr = ADDR_W'(k_q);
		end
	end

	obps_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Query evaluation against the last build
	assign q_bit = rdata[num_q[3:1]];
	always_comb begin
		q_status = ST_OK;
		q_prime  = 1'b0;
		priority if (!map_valid_q) begin
			q_status = ST_NOT_BUILT;
		end else if (num_q > NUM_W'(built_limit_q)) begin
			q_status = ST_RANGE;
		end else if (num_q < NUM_W'(2)) begin
			q_prime = 1'b0;
		end else if (num_q == NUM_W'(2)) begin
			q_prime = 1'b1;
		end else if (!num_q[0]) begin
			q_prime = 1'b0;
		end else begin
			q_prime = q_bit;
		end
	end

	assign acc_sum = acc_q + CNT_W'(ones8(rdata));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_limit_q  <= LIM_W'(2);
			map_valid_q    <= 1'b0;
			stored_count_q <= '0;
			built_limit_q  <= '0;
			acc_v_q        <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				upper_limit_q <= cfg_data;
			end
			acc_v_q <= cmd.cnt_rd;
			if (cmd.cnt_commit) begin
				stored_count_q <= acc_sum + CNT_W'(lim_q >= LIM_W'(2));
				built_limit_q  <= lim_q;
				map_valid_q    <= 1'b1;
			end
			if (cmd.load_build || cmd.load_query) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.build_start) begin
			lim_q   <= lim_d;
			top_q   <= top_d;
			k_q     <= '0;
			phase_q <= '0;
			p_q     <= INIT_P;
			sq_q    <= INIT_SQ;
			acc_q   <= '0;
		end
		if (cmd.q_accept) begin
			num_q <= query_number;
		end
		// Advance the fill and count sweeps
		if (cmd.fill_wr) begin
			k_q <= k_q + BYTE_W'(1);
			if (k_q != '0) begin
				phase_q <= PHASE_NEXT[phase_q];
			end
		end
		if (cmd.cnt_init) begin
			k_q <= '0;
		end
		if (cmd.cnt_rd) begin
			k_q <= k_q + BYTE_W'(1);
		end
		// Step to the next odd candidate: (p+2)^2 = p^2 + 4p + 4
		if (cmd.p_adv) begin
			p_q  <= p_q + P_W'(2);
			sq_q <= sq_q + SQ_W'({p_q, 2'b00}) + SQ_W'(4);
		end
		if (cmd.j_init) begin
			j_q <= IDX_W'(sq_q >> 1);
		end
		if (cmd.clr_wr) begin
			j_q <= j_q + IDX_W'(p_q);
		end
		if (acc_v_q) begin
			acc_q <= acc_sum;
		end
		// Load the output register
		if (cmd.load_build) begin
			is_prime_q    <= 1'b0;
			prime_count_q <= stored_count_q;
			status_q      <= ST_OK;
		end else if (cmd.load_query) begin
			is_prime_q    <= q_prime;
			prime_count_q <= stored_count_q;
			status_q      <= q_status;
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign is_prime    = is_prime_q;
	assign prime_count = prime_count_q;
	assign status      = status_q;

endmodule

FILE: rtl/odd_bitmap_prime_sieve.sv
// ---------------------------------------------------------------------------
// odd_bitmap_prime_sieve
// Odd-only bitmap prime sieve with build and primality query items.
// ---------------------------------------------------------------------------
// A build item (tuser 0) sieves all numbers up to the configured limit,
// saturated to MAX_LIMIT, into a byte-wide map RAM holding one bit per odd
// number, and returns the prime count. A query item (tuser 1) returns
// whether tdata is prime, with status 1 when it lies above the limit of the
// last build and status 2 before any build. Everything goes through the one
// map RAM, so items are worked one at a time. A build with T = (limit-1)/2
// sweeps its T/8+1 map bytes twice, for the fill and the count (one byte per
// cycle), and for each candidate still set up to sqrt(limit) clears its odd
// multiples from p*p on, each by a read-modify-write of one map byte. No
// clearing pass follows reset. Results sit in an output register, so the
// next item is taken while one waits.
// Write the limit only while the block is idle; it applies from the next
// build on.
// ---------------------------------------------------------------------------
module odd_bitmap_prime_sieve
	import obps_pkg::LIM_W;
	import obps_pkg::NUM_W;
	import obps_pkg::CNT_W;
#(
	parameter int MAX_LIMIT = 1048576
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration: upper_limit
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LIM_W-1:0] cfg_data,
	// Input items
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] query_number
	input  logic             s_tuser,   // [0] kind
	// Result items
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [0] is_prime, [17:1] prime_count, [23:18] zero
	output logic [1:0]       m_tuser    // [1:0] status
);
	import obps_pkg::*;

	obps_cmd_t        cmd;
	obps_sts_t        sts;
	logic             is_prime;
	logic [CNT_W-1:0] prime_count;

	assign cfg_ready = 1'b1;

	obps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	obps_dp #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.query_number (NUM_W'(s_tdata)),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.is_prime     (is_prime),
		.prime_count  (prime_count),
		.status       (m_tuser)
	);

	// Pack the result item
	assign m_tdata = {6'b0, prime_count, is_prime};

endmodule

FILE: rtl/obps_checker.sv
// ---------------------------------------------------------------------------
// obps_checker
// Port-level checks of the prime sieve, bound to the top level.
// ---------------------------------------------------------------------------
module obps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import obps_pkg::*;

	// Take no new item in the cycle right after one is accepted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is being worked");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only defined status codes are produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_NOT_BUILT)
		else $error("undefined status code");

	// A prime answer only comes with status ok
	a_prime_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tuser == ST_OK)
		else $error("prime flag with non-ok status");

	// Before any build the count is still zero
	a_unbuilt_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_NOT_BUILT |-> m_tdata[17:1] == 17'd0)
		else $error("nonzero count before a build");

endmodule

bind odd_bitmap_prime_sieve obps_checker u_obps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/odd_bitmap_prime_sieve_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odd_bitmap_prime_sieve_tb
// Self-checking bench for the odd-only bitmap prime sieve. A short table of
// directed items covers the cases before any build, limits of zero, one and
// two, an odd limit, a limit written after a build, and a saturating limit.
// Random phases follow, each writing a new limit and then usually sending a
// build followed mostly by in-range queries. Every result is compared field
// by field with the typed result of its table row, else with a bench sieve.
// Both stream sides idle at random; the receiver stalls at length in one phase.
// ---------------------------------------------------------------------------
module odd_bitmap_prime_sieve_tb;
	import obps_pkg::*;

	localparam int MAX_LIM      = 1048576;
	localparam int MAP_BYTES    = ((MAX_LIM - 1) >> 4) + 1;
	localparam int RAND_ITEMS   = 1400;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 16;
	localparam int WATCHDOG_MAX = 8000000;

	// Map fill: byte 0 differs, the rest repeats every three bytes
	localparam logic [7:0] FIRST_FILL = 8'h6e;
	localparam logic [7:0] FILL_CYCLE [0:2] = '{8'd219, 8'd182, 8'd109};

	typedef struct packed {
		logic             is_prime;
		logic [CNT_W-1:0] count;
		status_t          status;
	} sieve_result_t;

	typedef struct packed {
		logic             set_cfg;
		logic [LIM_W-1:0] cfg_val;
		logic             kind;
		logic [NUM_W-1:0] num;
		logic             typed;
		sieve_result_t    res;
	} dir_row_t;

	localparam sieve_result_t NO_TYPED = '{1'b0, 17'd0, ST_OK};
	localparam int DIR_COUNT = 26;

	// Directed items; typed results only where they are obvious
	localparam dir_row_t DIR_ROWS [0:DIR_COUNT-1] = '{
		'{1'b0, 21'd0,        KIND_QUERY, 32'd0,          1'b1, '{1'b0, 17'd0,     ST_NOT_BUILT}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'hFFFFFFFF,   1'b1, '{1'b0, 17'd0,     ST_NOT_BUILT}},
		'{1'b0, 21'd0,        KIND_BUILD, 32'hFFFFFFFF,   1'b1, '{1'b0, 17'd1,     ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd2,          1'b1, '{1'b1, 17'd1,     ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd3,          1'b1, '{1'b0, 17'd1,     ST_RANGE}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1,          1'b1, '{1'b0, 17'd1,     ST_OK}},
		'{1'b1, 21'd0,        KIND_BUILD, 32'd0,          1'b1, '{1'b0, 17'd0,     ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd0,          1'b1, '{1'b0, 17'd0,     ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1,          1'b1, '{1'b0, 17'd0,     ST_RANGE}},
		'{1'b1, 21'd1,        KIND_BUILD, 32'd0,          1'b1, '{1'b0, 17'd0,     ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1,          1'b1, '{1'b0, 17'd0,     ST_OK}},
		'{1'b1, 21'd97,       KIND_BUILD, 32'd0,          1'b1, '{1'b0, 17'd25,    ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd97,         1'b1, '{1'b1, 17'd25,    ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd98,         1'b1, '{1'b0, 17'd25,    ST_RANGE}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd96,         1'b1, '{1'b0, 17'd25,    ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd91,         1'b0, NO_TYPED},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd25,         1'b0, NO_TYPED},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd9,          1'b0, NO_TYPED},
		'{1'b1, 21'd100,      KIND_QUERY, 32'd99,         1'b1, '{1'b0, 17'd25,    ST_RANGE}},
		'{1'b0, 21'd0,        KIND_BUILD, 32'd0,          1'b0, NO_TYPED},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd99,         1'b0, NO_TYPED},
		'{1'b1, 21'h1FFFFF,   KIND_BUILD, 32'd0,          1'b1, '{1'b0, 17'd82025, ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1048573,    1'b0, NO_TYPED},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1048576,    1'b1, '{1'b0, 17'd82025, ST_OK}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1048577,    1'b1, '{1'b0, 17'd82025, ST_RANGE}},
		'{1'b0, 21'd0,        KIND_QUERY, 32'd1048575,    1'b0, NO_TYPED}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LIM_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;   // [31:0] query_number
	logic             s_tuser;   // [0] kind
	logic             m_tvalid;
	logic             m_tready;
	logic [23:0]      m_tdata;   // [0] is_prime, [17:1] prime_count, [23:18] zero
	logic [1:0]       m_tuser;   // [1:0] status

	// Bench copy of the sieve state and the limit register
	logic [7:0]       odd_map [0:MAP_BYTES-1];
	logic [CNT_W-1:0] prime_total;
	logic             map_built;
	int unsigned      built_lim;
	int unsigned      cur_limit;

	sieve_result_t pending_answers [$];
	int errors;
	int items_sent;
	int builds_sent;
	int queries_sent;
	int results_seen;
	int limits_set;
	int stall_cycles;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	logic idle_on;

	odd_bitmap_prime_sieve #(.MAX_LIMIT(MAX_LIM)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sieve the map up to the current limit and latch the count
	function automatic void sieve_build();
		int unsigned lim;
		int unsigned top;
		int unsigned last_byte;
		int unsigned p;
		int unsigned j;
		int unsigned k;
		int unsigned ph;
		int unsigned total;
		lim = (cur_limit > MAX_LIM) ? MAX_LIM : cur_limit;
		top = (lim >= 1) ? (lim - 1) >> 1 : 0;
		last_byte = top >> 3;
		odd_map[0] = FIRST_FILL;
		ph = 0;
		for (k = 1; k <= last_byte; k++) begin
			odd_map[k] = FILL_CYCLE[ph];
			ph = (ph == 2) ? 0 : ph + 1;
		end
		for (p = 5; p * p <= lim; p += 2) begin
			if (odd_map[p >> 4][(p >> 1) & 7]) begin
				for (j = (p * p) >> 1; j <= top; j += p)
					odd_map[j >> 3][j & 7] = 1'b0;
			end
		end
		// Drop the bits above the limit in the last byte
		for (j = top + 1; j < (last_byte + 1) * 8; j++)
			odd_map[j >> 3][j & 7] = 1'b0;
		if (lim < 2)
			odd_map[0][0] = 1'b0;
		total = 0;
		for (k = 0; k <= last_byte; k++)
			total += $countones(odd_map[k]);
		if (lim >= 2)
			total++;
		prime_total = total[CNT_W-1:0];
		built_lim = lim;
		map_built = 1'b1;
	endfunction

	// Work out the result of one accepted item
	function automatic sieve_result_t predict_answer(logic kind, logic [NUM_W-1:0] num);
		sieve_result_t ans;
		ans.is_prime = 1'b0;
		ans.status = ST_OK;
		if (kind == KIND_BUILD)
			sieve_build();
		else if (!map_built)
			ans.status = ST_NOT_BUILT;
		else if (num > built_lim)
			ans.status = ST_RANGE;
		else if (num == 2)
			ans.is_prime = 1'b1;
		else if (num >= 3 && num[0])
			ans.is_prime = odd_map[num >> 4][(num >> 1) & 7];
		ans.count = prime_total;
		return ans;
	endfunction

	// Pick a query number, mostly odd and within the built limit
	function automatic logic [NUM_W-1:0] pick_query();
		int unsigned lim;
		int unsigned r;
		int unsigned v;
		lim = map_built ? built_lim : cur_limit;
		r = $urandom_range(99);
		if (r < 70) begin
			v = $urandom_range(lim) | 1;
			if (v > lim)
				v = lim;
		end else if (r < 85) begin
			v = $urandom_range(lim + 2);
		end else if (r < 90) begin
			v = $urandom_range(3);
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// Pick a limit: mostly small, now and then larger
	function automatic logic [LIM_W-1:0] pick_limit();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			return LIM_W'($urandom_range(2));
		else if (r < 60)
			return LIM_W'($urandom_range(300, 3));
		else if (r < 90)
			return LIM_W'($urandom_range(2000, 301));
		else if (r < 99)
			return LIM_W'($urandom_range(10000, 2001));
		else
			return LIM_W'($urandom_range(40000, 10001));
	endfunction

	// Offer one item after a random gap and record its expected result
	task automatic offer_item(input logic kind, input logic [NUM_W-1:0] num,
			input logic typed, input sieve_result_t typed_res);
		sieve_result_t ans;
		if (idle_on && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (idle_on && $urandom_range(99) < 26);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= num;
		do @(posedge clk); while (!s_tready);
		ans = predict_answer(kind, num);
		pending_answers.push_back(typed ? typed_res : ans);
		items_sent++;
		if (kind == KIND_BUILD)
			builds_sent++;
		else
			queries_sent++;
	endtask

	// Stop offering and wait until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// Write the limit register; only called while the block is idle
	task automatic write_limit(input logic [LIM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_limit = value;
		limits_set++;
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (idle_on && $urandom_range(99) < 26) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		sieve_result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				$error("unexpected result: tdata %h tuser %0d", m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[0] !== want.is_prime) begin
					$error("is_prime: expected %0d, actual %0d", want.is_prime, m_tdata[0]);
					errors++;
				end
				if (m_tdata[17:1] !== want.count) begin
					$error("prime_count: expected %0d, actual %0d", want.count, m_tdata[17:1]);
					errors++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_MAX) begin
			$display("Timeout after %0d idle cycles", stall_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int row;
		int phase_no;
		int n;
		int i;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = KIND_BUILD;
		m_tready     = 1'b0;
		idle_on      = 1'b1;
		errors       = 0;
		items_sent   = 0;
		builds_sent  = 0;
		queries_sent = 0;
		results_seen = 0;
		limits_set   = 0;
		stall_cycles = 0;
		hold_reqs    = 0;
		hold_seen    = 0;
		hold_left    = 0;
		map_built    = 1'b0;
		prime_total  = '0;
		built_lim    = 0;
		cur_limit    = 2;

		// Hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (row = 0; row < DIR_COUNT; row++) begin
			if (DIR_ROWS[row].set_cfg) begin
				drain_results();
				write_limit(DIR_ROWS[row].cfg_val);
			end
			offer_item(DIR_ROWS[row].kind, DIR_ROWS[row].num,
				DIR_ROWS[row].typed, DIR_ROWS[row].res);
		end

		// Random phases: new limit, then usually a build and mostly in-range queries
		phase_no = 0;
		while (items_sent < DIR_COUNT + RAND_ITEMS) begin
			drain_results();
			write_limit(pick_limit());
			idle_on = (phase_no != 3);
			n = (phase_no == 3) ? 150 : $urandom_range(80, 30);
			for (i = 0; i < n; i++) begin
				if (i == 0 && $urandom_range(9) != 0) begin
					offer_item(KIND_BUILD, $urandom, 1'b0, NO_TYPED);
				end else if (i == n / 2 && phase_no % 4 == 1) begin
					// Pause until every result is back
					drain_results();
					offer_item(KIND_QUERY, pick_query(), 1'b0, NO_TYPED);
				end else if (i == 2 && phase_no == 5) begin
					// Hold the receiver off while items keep coming
					hold_reqs <= hold_reqs + 1;
					offer_item(KIND_QUERY, pick_query(), 1'b0, NO_TYPED);
				end else if ($urandom_range(99) < 4) begin
					offer_item(KIND_BUILD, $urandom, 1'b0, NO_TYPED);
				end else begin
					offer_item(KIND_QUERY, pick_query(), 1'b0, NO_TYPED);
				end
			end
			phase_no++;
		end
		idle_on = 1'b1;

		// Let the last results drain and the block settle
		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d builds and %0d queries over %0d limit settings; %0d results compared.",
			builds_sent, queries_sent, limits_set, results_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
